/* hdl/ewma_relative_deviation_defines.svh */
// Assertion macros used by the top-level design file.
`ifndef EWMA_RELATIVE_DEVIATION_DEFINES_SVH
`define EWMA_RELATIVE_DEVIATION_DEFINES_SVH

// Same-cycle implication: when a holds, c must hold at the same edge.
`define EWMARD_ASSERT_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("ewmard: same-cycle check failed");

// Next-cycle implication: when a holds, c must hold at the next edge.
`define EWMARD_ASSERT_NXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("ewmard: next-cycle check failed");

`endif

/* hdl/ewmard_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ewmard_pkg;

    localparam int PRICE_W   = 48;
    localparam int DECAY_W   = 16;
    localparam int DEV_W     = 32;
    localparam int FRAC_OUT  = 16;
    localparam int DIFF_W    = PRICE_W + 1;
    localparam int MUL_SPLIT = 24;
    localparam int PLO_W     = MUL_SPLIT + DECAY_W;
    localparam int PHI_W     = DIFF_W - MUL_SPLIT + DECAY_W + 1;
    localparam int PROD_W    = DIFF_W + DECAY_W + 1;
    localparam int SUM_W     = PRICE_W + 3;
    localparam int REM_W     = PRICE_W + 1;
    localparam int DIV_STEPS = DEV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(52016);

    localparam logic [1:0] MODE_PRICE  = 2'd0;
    localparam logic [1:0] MODE_RESET  = 2'd1;
    localparam logic [1:0] MODE_INTR   = 2'd2;
    localparam logic [1:0] MODE_RESUME = 2'd3;

    localparam logic [1:0] KIND_SHIFT  = 2'd0;
    localparam logic [1:0] KIND_INTR   = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;

    typedef struct packed {
        logic capture;
        logic first;
        logic set_int;
        logic clr_int;
        logic shift;
        logic diff_load;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic avg_upd;
        logic res_zero;
        logic div_sub;
        logic div_abs;
        logic res_sat;
        logic div_step;
        logic res_div;
        logic emit;
    } ewmard_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] kind;
        logic       ready;
        logic       intr;
        logic       avg_zero;
        logic       div_ovf;
    } ewmard_sts_t;

endpackage

`default_nettype wire

/* hdl/ewmard_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ewmard_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    input  wire ewmard_pkg::ewmard_sts_t sts,
    output ewmard_pkg::ewmard_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_MUL_LO  = 4'd2;
    localparam logic [3:0] S_MUL_HI  = 4'd3;
    localparam logic [3:0] S_SUM     = 4'd4;
    localparam logic [3:0] S_AVG     = 4'd5;
    localparam logic [3:0] S_DIV_SUB = 4'd6;
    localparam logic [3:0] S_DIV_ABS = 4'd7;
    localparam logic [3:0] S_DIV_CHK = 4'd8;
    localparam logic [3:0] S_DIV_RUN = 4'd9;
    localparam logic [3:0] S_DIV_FIN = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    logic [3:0]                   state_reg, state_next;
    logic [ewmard_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.mode)
                    ewmard_pkg::MODE_PRICE:
                    begin
                        if (!sts.ready)
                        begin
                            cmd.first    = 1'b1;
                            cmd.res_zero = 1'b1;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            cmd.diff_load = 1'b1;
                            state_next    = S_MUL_LO;
                        end
                    end
                    ewmard_pkg::MODE_RESET:
                    begin
                        case (sts.kind)
                            ewmard_pkg::KIND_SHIFT:
                            begin
                                cmd.shift  = 1'b1;
                                state_next = S_IDLE;
                            end
                            ewmard_pkg::KIND_INTR:
                            begin
                                cmd.set_int  = 1'b1;
                                cmd.res_zero = 1'b1;
                                state_next   = S_EMIT;
                            end
                            ewmard_pkg::KIND_RESUME:
                            begin
                                cmd.clr_int = 1'b1;
                                state_next  = S_IDLE;
                            end
                            default:
                            begin
                                // unused kind: drop the word
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                    ewmard_pkg::MODE_INTR:
                    begin
                        cmd.set_int  = 1'b1;
                        cmd.res_zero = 1'b1;
                        state_next   = S_EMIT;
                    end
                    default:
                    begin
                        cmd.clr_int = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                cmd.avg_upd = 1'b1;
                state_next  = S_DIV_SUB;
            end
            S_DIV_SUB:
            begin
                if (sts.intr || sts.avg_zero)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.div_sub = 1'b1;
                    state_next  = S_DIV_ABS;
                end
            end
            S_DIV_ABS:
            begin
                cmd.div_abs = 1'b1;
                cnt_next    = '0;
                state_next  = S_DIV_CHK;
            end
            S_DIV_CHK:
            begin
                if (sts.div_ovf)
                begin
                    cmd.res_sat = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_DIV_RUN;
                end
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == ewmard_pkg::CNT_W'(ewmard_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIV_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_FIN:
            begin
                cmd.res_div = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/ewmard_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ewmard_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ewmard_pkg::DECAY_W-1:0]       cfg_wr_data,
    input  wire logic [1:0]                           mode,
    input  wire logic signed [ewmard_pkg::PRICE_W-1:0] new_price,
    input  wire logic signed [ewmard_pkg::PRICE_W-1:0] old_price,
    input  wire logic [1:0]                           reset_kind,
    input  wire ewmard_pkg::ewmard_cmd_t              cmd,
    output ewmard_pkg::ewmard_sts_t                   sts,
    output logic signed [ewmard_pkg::DEV_W-1:0]       deviation
);

    localparam int PW = ewmard_pkg::PRICE_W;
    localparam int SW = ewmard_pkg::SUM_W;
    localparam int DW = ewmard_pkg::DEV_W;
    localparam int RW = ewmard_pkg::REM_W;
    localparam int FO = ewmard_pkg::FRAC_OUT;
    localparam int XW = ewmard_pkg::DIFF_W;
    localparam int MS = ewmard_pkg::MUL_SPLIT;
    localparam int PR = ewmard_pkg::PROD_W;
    localparam int KW = ewmard_pkg::DECAY_W;

    localparam logic [DW-1:0] DEV_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] DEV_MAX = {1'b0, {(DW-1){1'b1}}};

    // Clamp a widened sum back to the price range.
    function automatic logic [PW-1:0] sat_price(input logic [SW-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SW-1:PW-1];
        hi_zeros = ~|v[SW-1:PW-1];
        if (hi_ones || hi_zeros)
        begin
            return v[PW-1:0];
        end
        else if (v[SW-1])
        begin
            return {1'b1, {(PW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(PW-1){1'b1}}};
        end
    endfunction

    // Control state
    logic [KW-1:0] decay_reg;
    logic [PW-1:0] avg_reg, avg_next;
    logic          ready_reg, ready_next;
    logic          intr_reg, intr_next;

    // Payload registers
    logic [1:0]                     mode_reg;
    logic [1:0]                     kind_reg;
    logic [PW-1:0]                  price_reg;
    logic [PW-1:0]                  oldp_reg;
    logic [XW-1:0]                  diff_reg;
    logic [ewmard_pkg::PLO_W-1:0]   plo_reg;
    logic signed [ewmard_pkg::PHI_W-1:0] phi_reg;
    logic [PR-1:0]                  prod_reg;
    logic [XW-1:0]                  num_reg;
    logic [PW-1:0]                  dd_reg;
    logic                           neg_reg;
    logic [RW-1:0]                  rem_reg;
    logic [DW-1:0]                  sh_reg;
    logic [DW-1:0]                  q_reg;
    logic [DW-1:0]                  res_reg;
    logic [DW-1:0]                  dev_reg;

    // Combinational helpers
    logic [PR-1:0] phi_ext;
    logic [PR-1:0] plo_ext;
    logic [PR-1:0] prod_next;
    logic [SW-1:0] upd_sum;
    logic [SW-1:0] shift_sum;
    logic [XW-1:0] abs_num;
    logic [PW-1:0] abs_avg;
    logic [RW-1:0] trial;
    logic          trial_ge;
    logic [DW-1:0] div_res;

    assign phi_ext   = {{(PR-ewmard_pkg::PHI_W){phi_reg[ewmard_pkg::PHI_W-1]}}, phi_reg};
    assign plo_ext   = {{(PR-ewmard_pkg::PLO_W){1'b0}}, plo_reg};
    // rounding bias: half an LSB of the decay scale
    assign prod_next = (phi_ext << MS) + plo_ext + (PR'(1) << (KW - 1));

    assign upd_sum   = {{(SW-PW){price_reg[PW-1]}}, price_reg}
                     + {{(SW-(PR-KW)){prod_reg[PR-1]}}, prod_reg[PR-1:KW]};
    assign shift_sum = {{(SW-PW){avg_reg[PW-1]}}, avg_reg}
                     - {{(SW-PW){oldp_reg[PW-1]}}, oldp_reg}
                     + {{(SW-PW){price_reg[PW-1]}}, price_reg};

    assign abs_num  = num_reg[XW-1] ? (~num_reg + 1'b1) : num_reg;
    assign abs_avg  = avg_reg[PW-1] ? (~avg_reg + 1'b1) : avg_reg;

    assign trial    = {rem_reg[RW-2:0], sh_reg[DW-1]};
    assign trial_ge = trial >= {1'b0, dd_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            div_res = (q_reg > DEV_MIN) ? DEV_MIN : (~q_reg + 1'b1);
        end
        else
        begin
            div_res = q_reg[DW-1] ? DEV_MAX : q_reg;
        end
    end

    always_comb
    begin
        avg_next   = avg_reg;
        ready_next = ready_reg;
        intr_next  = intr_reg;
        if (cmd.first)
        begin
            avg_next   = price_reg;
            ready_next = 1'b1;
        end
        if (cmd.avg_upd)
        begin
            avg_next = sat_price(upd_sum);
        end
        if (cmd.shift)
        begin
            avg_next = sat_price(shift_sum);
        end
        if (cmd.set_int)
        begin
            intr_next = 1'b1;
        end
        if (cmd.clr_int)
        begin
            intr_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= ewmard_pkg::DECAY_RESET;
            avg_reg   <= '0;
            ready_reg <= 1'b0;
            intr_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decay_reg <= cfg_wr_data;
            end
            avg_reg   <= avg_next;
            ready_reg <= ready_next;
            intr_reg  <= intr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            kind_reg  <= reset_kind;
            price_reg <= new_price;
            oldp_reg  <= old_price;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= {avg_reg[PW-1], avg_reg} - {price_reg[PW-1], price_reg};
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= diff_reg[MS-1:0] * decay_reg;
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= $signed(diff_reg[XW-1:MS]) * $signed({1'b0, decay_reg});
        end
        if (cmd.sum)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.div_sub)
        begin
            num_reg <= {price_reg[PW-1], price_reg} - {avg_reg[PW-1], avg_reg};
        end
        if (cmd.div_abs)
        begin
            dd_reg  <= abs_avg;
            neg_reg <= num_reg[XW-1] ^ avg_reg[PW-1];
            rem_reg <= {{(RW-(XW-FO)){1'b0}}, abs_num[XW-1:FO]};
            sh_reg  <= {abs_num[FO-1:0], {(DW-FO){1'b0}}};
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? (trial - {1'b0, dd_reg}) : trial;
            sh_reg  <= {sh_reg[DW-2:0], 1'b0};
            q_reg   <= {q_reg[DW-2:0], trial_ge};
        end
        if (cmd.res_zero)
        begin
            res_reg <= '0;
        end
        if (cmd.res_sat)
        begin
            res_reg <= neg_reg ? DEV_MIN : DEV_MAX;
        end
        if (cmd.res_div)
        begin
            res_reg <= div_res;
        end
        if (cmd.emit)
        begin
            dev_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.mode     = mode_reg;
        sts.kind     = kind_reg;
        sts.ready    = ready_reg;
        sts.intr     = intr_reg;
        sts.avg_zero = (avg_reg == '0);
        // integer part of the quotient would not fit in the output format
        sts.div_ovf  = (rem_reg >= {1'b0, dd_reg});
    end

    assign deviation = dev_reg;

endmodule

`default_nettype wire

/* hdl/ewma_relative_deviation.sv */
// Channel   | Handshake            | Word
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | mode, new_price, old_price, reset_kind
// output    | out_valid / out_ready| deviation
// config    | cfg_wr_en            | cfg_wr_data (decay factor, Q0.16)
//
// A price word that runs the full divide passes decode, the multiply, the
// average update, the divide check and the 32-step restoring divider (one
// quotient bit per cycle); a saturating quotient skips the steps. First
// prices and interrupts emit zero from decode, flag-only words end there,
// and interrupted or zero-average prices skip the divide after the update.
// Reset (rst_n, async, active low) clears the average, the ready and
// interrupted flags, and loads the decay factor with its default.
// One word is in flight at a time; a finished result waits in the output
// register, and the block stalls in place if it is still full.
`timescale 1ns / 1ps
`default_nettype none
`include "ewma_relative_deviation_defines.svh"

module ewma_relative_deviation (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_wr_en,
    input  wire logic [ewmard_pkg::DECAY_W-1:0]        cfg_wr_data,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            mode,
    input  wire logic signed [ewmard_pkg::PRICE_W-1:0] new_price,
    input  wire logic signed [ewmard_pkg::PRICE_W-1:0] old_price,
    input  wire logic [1:0]                            reset_kind,
    // output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [ewmard_pkg::DEV_W-1:0]        deviation
);

    // Commands flow from the sequencer to the datapath; status flows back.
    ewmard_pkg::ewmard_cmd_t cmd;
    ewmard_pkg::ewmard_sts_t sts;
    logic [6:0]              major_cmd;

    // Sequencer: decodes the word, steps the multiply, average update and
    // divide, then parks the result in the output register.
    ewmard_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: average, flags, split multiplier, bit-serial divider and
    // the output register.
    ewmard_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mode        (mode),
        .new_price   (new_price),
        .old_price   (old_price),
        .reset_kind  (reset_kind),
        .cmd         (cmd),
        .sts         (sts),
        .deviation   (deviation)
    );

    // Major sequencing commands, one per sequencer step.
    assign major_cmd = {cmd.capture, cmd.mul_lo, cmd.mul_hi, cmd.sum,
                        cmd.avg_upd, cmd.div_step, cmd.emit};

    // No new word is taken in the cycle after one is captured.
    `EWMARD_ASSERT_NXT(a_one_in_flight, clk, rst_n, cmd.capture, !in_ready)
    // An emitted result is presented on the next cycle.
    `EWMARD_ASSERT_NXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid)
    // Major sequencing commands never overlap.
    `EWMARD_ASSERT_IMP(a_cmd_excl, clk, rst_n, 1'b1, $onehot0(major_cmd))
    // The divider only iterates while the input side is closed.
    `EWMARD_ASSERT_IMP(a_div_busy, clk, rst_n, cmd.div_step, !in_ready)

endmodule

`default_nettype wire

/* verif/ewma_relative_deviation_tb.sv */
`timescale 1ns / 1ps

module ewma_relative_deviation_tb;

    import ewmard_pkg::*;

    // Price range of the signed 48-bit Q31.16 format, one price unit,
    // and the reset kind that the block ignores.
    localparam longint PX_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint PX_LO = -PX_HI - 1;
    localparam longint ONE = 65536;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Run shape: words per random phase, the cycles to let a word that
    // yields no result finish, the long output stall and the watchdog.
    localparam int PHASE_WORDS = 200;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_AT = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    // One input word plus, for directed rows, a result that is obvious
    // from the behavior and typed in by hand.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [47:0] px_new;
        logic signed [47:0] px_old;
        logic [1:0]         kind;
        logic               fixed;
        logic [31:0]        fixed_dev;
    } market_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [DECAY_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] mode;
    logic signed [PRICE_W-1:0] new_price;
    logic signed [PRICE_W-1:0] old_price;
    logic [1:0] reset_kind;
    logic out_valid;
    logic out_ready;
    logic signed [DEV_W-1:0] deviation;

    // Mirror of the block state, advanced at each accepted input word.
    longint avg_price;
    bit is_primed;
    bit is_halted;
    logic [DECAY_W-1:0] decay_now;

    // Deviations still owed by the block, oldest first.
    logic [31:0] expected_deviation_q[$];
    market_word_t directed_rows[$];

    longint price_level;
    bit calm;
    int mismatches;
    int results_checked;
    int words_offered;
    int saturated_seen;
    int zero_seen;
    int decay_settings;
    int cycle_count;

    ewma_relative_deviation dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .new_price   (new_price),
        .old_price   (old_price),
        .reset_kind  (reset_kind),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .deviation   (deviation)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: give up if the run has not ended well past its slowest pace.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d deviations still owed",
                     cycle_count, expected_deviation_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint clamp48(longint v);
        if (v > PX_HI)
            return PX_HI;
        if (v < PX_LO)
            return PX_LO;
        return v;
    endfunction

    // round(gap * d / 2^16), ties toward +infinity, computed exactly:
    // split the gap into a floored upper part and a 16-bit remainder.
    function automatic longint decay_blend(longint gap, longint unsigned d);
        longint unsigned r;
        longint unsigned lo;
        longint q;
        r = gap & 64'hFFFF;
        q = gap >>> 16;
        lo = (r * d + 64'd32768) >> 16;
        return q * longint'(d) + longint'(lo);
    endfunction

    // num / den in Q15.16, truncated toward zero, saturated to 32 bits.
    function automatic logic [31:0] rel_quotient(longint num, longint den);
        bit neg;
        longint unsigned n;
        longint unsigned dd;
        longint unsigned qi;
        longint unsigned rem;
        longint unsigned mag;
        neg = (num < 0) != (den < 0);
        if (num < 0)
            n = -num;
        else
            n = num;
        if (den < 0)
            dd = -den;
        else
            dd = den;
        qi = n / dd;
        rem = n % dd;
        if (qi >= 64'd65536)
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        // rem < dd < 2^48, so the shifted remainder still fits 64 bits
        mag = (qi << 16) | ((rem << 16) / dd);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            mag = ~mag + 64'd1;
            return mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Advance the mirrored state by one word; report whether it yields a
    // deviation and which.
    function automatic void ewma_track(input market_word_t w, output bit emits,
                                       output logic [31:0] dev);
        longint price;
        longint prior;
        price = longint'($signed(w.px_new));
        prior = longint'($signed(w.px_old));
        emits = 1'b0;
        dev = '0;
        case (w.op)
            MODE_PRICE:
            begin
                if (!is_primed)
                begin
                    is_primed = 1'b1;
                    avg_price = price;
                end
                else
                begin
                    avg_price = clamp48(price + decay_blend(avg_price - price,
                                                            decay_now));
                    if (avg_price != 0)
                        dev = rel_quotient(price - avg_price, avg_price);
                end
                if (is_halted)
                    dev = '0;
                emits = 1'b1;
            end
            MODE_RESET:
            begin
                if (w.kind == KIND_INTR)
                begin
                    is_halted = 1'b1;
                    emits = 1'b1;
                end
                else if (w.kind == KIND_RESUME)
                    is_halted = 1'b0;
                else if (w.kind == KIND_SHIFT)
                    avg_price = clamp48(avg_price - (prior - price));
            end
            MODE_INTR:
            begin
                is_halted = 1'b1;
                emits = 1'b1;
            end
            default:
                is_halted = 1'b0;
        endcase
    endfunction

    function automatic market_word_t word_of(logic [1:0] op, longint px_new,
                                             longint px_old, logic [1:0] kind,
                                             logic fixed = 1'b0,
                                             logic [31:0] fixed_dev = '0);
        market_word_t w;
        w.op = op;
        w.px_new = 48'(px_new);
        w.px_old = 48'(px_old);
        w.kind = kind;
        w.fixed = fixed;
        w.fixed_dev = fixed_dev;
        return w;
    endfunction

    function automatic longint any_price();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return longint'($signed(raw[47:0]));
    endfunction

    // Prices mostly wander around a level, so the average tracks them;
    // the rest are jumps, extremes and values near zero, which drive the
    // average across zero and the deviation into saturation.
    function automatic longint next_price();
        int unsigned pick;
        longint span;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            span = longint'(1) << $urandom_range(4, 24);
            price_level = clamp48(price_level
                                  + longint'($urandom_range(0, 32'(2 * span))) - span);
            return price_level;
        end
        if (pick < 70)
            return any_price();
        if (pick < 80)
        begin
            case ($urandom_range(4))
                0: return PX_HI;
                1: return PX_LO;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
        end
        if (pick < 90)
            return longint'($urandom_range(0, 131072)) - 65536;
        price_level = (longint'(1) << $urandom_range(0, 46))
                      + longint'($urandom_range(0, 65535));
        if ($urandom_range(1) == 1)
            price_level = -price_level;
        return price_level;
    endfunction

    // Fields a mode does not use carry random noise.
    function automatic market_word_t random_word();
        market_word_t w;
        int unsigned pick;
        longint p;
        w = word_of(MODE_PRICE, any_price(), any_price(), 2'($urandom_range(3)));
        pick = $urandom_range(99);
        if (pick < 72)
            w.px_new = 48'(next_price());
        else if (pick < 80)
        begin
            w.op = MODE_RESET;
            w.kind = KIND_SHIFT;
            p = next_price();
            w.px_new = 48'(p);
            case ($urandom_range(3))
                0, 1: w.px_old = 48'(clamp48(p + longint'($urandom_range(0, 1 << 20))
                                              - (1 << 19)));
                2: ;
                default: w.px_old = ($urandom_range(1) == 1) ? 48'(PX_HI) : 48'(PX_LO);
            endcase
        end
        else if (pick < 84)
        begin
            w.op = MODE_RESET;
            w.kind = KIND_INTR;
        end
        else if (pick < 88)
        begin
            w.op = MODE_RESET;
            w.kind = KIND_RESUME;
        end
        else if (pick < 90)
        begin
            w.op = MODE_RESET;
            w.kind = KIND_UNUSED;
        end
        else if (pick < 94)
            w.op = MODE_INTR;
        else
            w.op = MODE_RESUME;
        return w;
    endfunction

    // Offer one word, hold it until accepted, then log what it owes.
    // Valid stays high from one word to the next unless an idle gap falls.
    task automatic offer_word(input market_word_t w);
        bit emits;
        logic [31:0] dev;
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= w.op;
        new_price <= w.px_new;
        old_price <= w.px_old;
        reset_kind <= w.kind;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ewma_track(w, emits, dev);
        if (emits)
            expected_deviation_q.push_back(w.fixed ? w.fixed_dev : dev);
        words_offered++;
    endtask

    // Drop valid and wait until every owed deviation has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_deviation_q.size() != 0);
    endtask

    // Write the decay only while the block is idle: drain, then let any
    // word that yields no result run out before the write.
    task automatic set_decay(input logic [DECAY_W-1:0] value);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        decay_now = value;
        decay_settings++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Output side: accept at random, except for one long hold-off that
    // fills the block and stalls its input, and a calm stretch.
    initial
    begin : receiver
        int stall_left;
        bit held;
        logic [31:0] want;
        stall_left = 0;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_deviation_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: deviation expected none, actual 0x%08h",
                             $time, deviation);
                end
                else
                begin
                    want = expected_deviation_q.pop_front();
                    if (deviation !== want)
                    begin
                        mismatches++;
                        $display("%0t: deviation expected 0x%08h, actual 0x%08h",
                                 $time, want, deviation);
                    end
                    if (want == 32'h7FFF_FFFF || want == 32'h8000_0000)
                        saturated_seen++;
                    if (want == 32'h0)
                        zero_seen++;
                    results_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (results_checked == HOLD_AT && !held)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || $urandom_range(99) >= 16;
        end
    end

    initial
    begin : sender
        logic [DECAY_W-1:0] decay_plan[7];
        int useful;
        market_word_t w;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        mode = MODE_PRICE;
        new_price = '0;
        old_price = '0;
        reset_kind = KIND_SHIFT;
        calm = 1'b0;
        mismatches = 0;
        results_checked = 0;
        words_offered = 0;
        saturated_seen = 0;
        zero_seen = 0;
        decay_settings = 1;
        cycle_count = 0;
        price_level = 100 * ONE;
        avg_price = 0;
        is_primed = 1'b0;
        is_halted = 1'b0;
        decay_now = DECAY_RESET;

        // Directed words under the reset decay. Zero results after a first
        // price, an interrupt, or with the flag set are typed in by hand.
        // shift before the first price; the first price then overwrites it
        directed_rows.push_back(word_of(MODE_RESET, 100 * ONE, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, 0, PX_HI, KIND_UNUSED, 1'b1, '0));
        // average stays at zero: deviation forced to zero
        directed_rows.push_back(word_of(MODE_PRICE, 0, PX_LO, KIND_SHIFT, 1'b1, '0));
        directed_rows.push_back(word_of(MODE_PRICE, ONE, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, 2 * ONE, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, PX_HI, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, PX_LO, 0, KIND_SHIFT));
        // shifts that saturate low, then land the average on -1
        directed_rows.push_back(word_of(MODE_RESET, PX_LO, PX_HI, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_RESET, PX_HI, 0, KIND_SHIFT));
        // tiny price pulls the average onto zero
        directed_rows.push_back(word_of(MODE_PRICE, 2, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, PX_HI, 0, KIND_SHIFT));
        // shift that saturates high
        directed_rows.push_back(word_of(MODE_RESET, PX_HI, PX_LO, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, 3 * ONE, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_INTR, -1, -1, KIND_RESUME, 1'b1, '0));
        directed_rows.push_back(word_of(MODE_PRICE, 5 * ONE, 0, KIND_SHIFT, 1'b1, '0));
        directed_rows.push_back(word_of(MODE_RESUME, 0, 0, KIND_INTR));
        directed_rows.push_back(word_of(MODE_RESET, 0, 0, KIND_INTR, 1'b1, '0));
        directed_rows.push_back(word_of(MODE_PRICE, -3 * ONE, 0, KIND_SHIFT, 1'b1, '0));
        directed_rows.push_back(word_of(MODE_RESET, 0, 0, KIND_RESUME));
        // unused reset kind with extreme prices: no effect at all
        directed_rows.push_back(word_of(MODE_RESET, PX_HI, PX_LO, KIND_UNUSED));
        directed_rows.push_back(word_of(MODE_PRICE, -3 * ONE, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_RESET, 7 * ONE, -3 * ONE, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, 7 * ONE, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, -1, 0, KIND_SHIFT));
        directed_rows.push_back(word_of(MODE_PRICE, 1, 0, KIND_SHIFT));

        // Decay settings for the random phases; the first runs with no idling.
        decay_plan[0] = 16'hFFFF;
        decay_plan[1] = 16'd0;
        decay_plan[2] = 16'd1;
        decay_plan[3] = 16'($urandom());
        decay_plan[4] = 16'd32768;
        decay_plan[5] = DECAY_RESET;
        decay_plan[6] = 16'($urandom());

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_word(directed_rows[i]);

        for (int phase = 0; phase < 7; phase++)
        begin
            set_decay(decay_plan[phase]);
            calm = (phase == 0);
            useful = 0;
            while (useful < PHASE_WORDS)
            begin
                // once, pause the input until nothing is owed
                if (phase == 3 && useful == 100)
                    drain_results();
                w = random_word();
                offer_word(w);
                if (!(w.op == MODE_RESET && w.kind == KIND_UNUSED))
                    useful++;
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input words over %0d decay settings, %0d deviations checked",
                 words_offered, decay_settings, results_checked);
        $display("of those %0d were saturated and %0d zero; %0d mismatches",
                 saturated_seen, zero_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* ewma_relative_deviation.f */
+incdir+hdl
hdl/ewmard_pkg.sv
hdl/ewmard_ctrl.sv
hdl/ewmard_dp.sv
hdl/ewma_relative_deviation.sv
verif/ewma_relative_deviation_tb.sv
